>>> design/csse_pkg.sv
// Shared constants and types for the cardinal/Hermite spline segment evaluator.
package csse_pkg;

    // Fixed formats
    localparam int T_WIDTH     = 16;               // t word, unsigned Q1.15
    localparam int T_FRAC      = 15;
    localparam int T_HALF      = 1 << (T_FRAC - 1);
    localparam int GUARD_BITS  = 8;                // extra fraction bits in coefficients
    localparam int G_HALF      = 1 << (GUARD_BITS - 1);
    localparam int CF_SHIFT    = T_FRAC - GUARD_BITS;
    localparam int CF_HALF     = 1 << (CF_SHIFT - 1);
    localparam int POINT_WIDTH = 48;
    localparam int TENS_WIDTH  = 16;

    // Register map
    localparam int REG_IDX_W = 3;
    typedef logic [REG_IDX_W-1:0] t_reg_idx;

    localparam t_reg_idx REG_CURVE_MODE   = 3'd0;
    localparam t_reg_idx REG_POINT_BEFORE = 3'd1;
    localparam t_reg_idx REG_POINT_START  = 3'd2;
    localparam t_reg_idx REG_POINT_END    = 3'd3;
    localparam t_reg_idx REG_POINT_AFTER  = 3'd4;
    localparam t_reg_idx REG_TENSION      = 3'd5;

    localparam logic MODE_CARDINAL = 1'b0;
    localparam logic MODE_HERMITE  = 1'b1;

    localparam logic [TENS_WIDTH-1:0] TENSION_RST = 16'd6554;

    // Coefficient builder depth and the matching input hold-off counter
    localparam int BUILD_LAT = 3;
    localparam int BUSY_W    = 2;

    // Horner pipeline depth (three multiply stages, three add stages, one round/saturate)
    localparam int HORNER_STAGES = 7;

    typedef logic [T_WIDTH-1:0]     t_tval;
    typedef logic [POINT_WIDTH-1:0] t_point;

endpackage

>>> design/csse_if.sv
// Handshake channels of the spline evaluator: config write, t input, point output.

interface csse_cfg_if import csse_pkg::*; ();
    logic     valid;
    logic     ready;
    t_reg_idx reg_index;
    t_point   wr_data;

    modport source (output valid, output reg_index, output wr_data, input ready);
    modport sink   (input valid, input reg_index, input wr_data, output ready);
endinterface

interface csse_in_if import csse_pkg::*; ();
    logic  valid;
    logic  ready;
    t_tval t_param;

    modport source (output valid, output t_param, input ready);
    modport sink   (input valid, input t_param, output ready);
endinterface

interface csse_out_if #(parameter int COORD_WIDTH = 16) ();
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] pos_x;
    logic signed [COORD_WIDTH-1:0] pos_y;
    logic signed [COORD_WIDTH-1:0] pos_z;

    modport source (output valid, output pos_x, output pos_y, output pos_z, input ready);
    modport sink   (input valid, input pos_x, input pos_y, input pos_z, output ready);
endinterface

>>> design/cardinal_spline_segment_eval_core.sv
// Cubic spline segment evaluator: coefficient builder plus pipelined Horner datapath.
//
// Evaluates one 3D cubic segment p(t) = a*t^3 + b*t^2 + c*t + d per axis. The config port
// holds the mode (cardinal from four control points with tension, or Hermite from two end
// points and two tangents), the four packed points (x in the low COORD_WIDTH bits, then y,
// then z) and the tension in Q1.15. Each input word carries t in Q1.15 (any 16-bit value is
// evaluated as given) and yields one output word with x, y, z saturated to COORD_WIDTH bits,
// same fixed-point format as the points. Throughput is one point per clock while no
// rebuild runs: every stage of the seven-stage Horner pipeline (multiply, round-and-add,
// three times, then a final round/saturate) holds its own valid bit, so a new t is taken
// every cycle outside a rebuild and a stalled output only backs up stages that are full.
// After reset and after any config write, per-axis coefficients are rebuilt in a
// three-stage builder (differences, tension products, sums with rounding); input ready
// stays low while that runs. The config port is always ready and must only be written
// while no points are in flight.
module cardinal_spline_segment_eval_core import csse_pkg::*; #(
    parameter int COORD_WIDTH = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    csse_cfg_if.sink     i_cfg,
    csse_in_if.sink      i_in,
    csse_out_if.source   o_out
);

    localparam int W   = COORD_WIDTH;
    localparam int EXW = (3 * W > POINT_WIDTH) ? 3 * W : POINT_WIDTH;
    localparam int SW  = TENS_WIDTH + 1;   // tension as signed operand
    localparam int SMW = W + 21;           // cardinal sums at scale 2^(T_FRAC)
    localparam int CFW = W + 13;           // stored coefficient width
    localparam int TW  = T_WIDTH + 1;      // t as signed operand
    localparam int P1W = CFW + TW;
    localparam int H1W = W + 16;
    localparam int P2W = H1W + TW;
    localparam int H2W = W + 18;
    localparam int P3W = H2W + TW;
    localparam int H3W = W + 19;

    localparam logic signed [H3W:0] SAT_MAX = {{(H3W + 2 - W){1'b0}}, {(W - 1){1'b1}}};
    localparam logic signed [H3W:0] SAT_MIN = {{(H3W + 2 - W){1'b1}}, {(W - 1){1'b0}}};

    // ------------------------------------------------------------------
    // Config registers
    // ------------------------------------------------------------------
    logic                  r_curve_mode;
    t_point                r_point_before;
    t_point                r_point_start;
    t_point                r_point_end;
    t_point                r_point_after;
    logic [TENS_WIDTH-1:0] r_tension;
    logic [BUSY_W-1:0]     r_busy;

    logic cfg_fire;
    assign i_cfg.ready = 1'b1;
    assign cfg_fire    = i_cfg.valid & i_cfg.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_curve_mode   <= MODE_CARDINAL;
            r_point_before <= '0;
            r_point_start  <= '0;
            r_point_end    <= '0;
            r_point_after  <= '0;
            r_tension      <= TENSION_RST;
        end else if (cfg_fire) begin
            unique case (i_cfg.reg_index)
                REG_CURVE_MODE:   r_curve_mode   <= i_cfg.wr_data[0];
                REG_POINT_BEFORE: r_point_before <= i_cfg.wr_data;
                REG_POINT_START:  r_point_start  <= i_cfg.wr_data;
                REG_POINT_END:    r_point_end    <= i_cfg.wr_data;
                REG_POINT_AFTER:  r_point_after  <= i_cfg.wr_data;
                REG_TENSION:      r_tension      <= i_cfg.wr_data[TENS_WIDTH-1:0];
                default: begin
                end
            endcase
        end
    end

    // Hold off input until the builder has flushed the new config through.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= BUSY_W'(BUILD_LAT);
        end else if (cfg_fire) begin
            r_busy <= BUSY_W'(BUILD_LAT);
        end else if (r_busy != '0) begin
            r_busy <= r_busy - 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Coefficient builder, free running off the config registers
    // ------------------------------------------------------------------
    logic [EXW-1:0]       ext_p0, ext_p1, ext_p2, ext_p3;
    logic signed [W-1:0]  c_p0 [3];
    logic signed [W-1:0]  c_p1 [3];
    logic signed [W-1:0]  c_p2 [3];
    logic signed [W-1:0]  c_p3 [3];

    // Coordinates past the end of a 48-bit register read as zero.
    assign ext_p0 = EXW'(r_point_before);
    assign ext_p1 = EXW'(r_point_start);
    assign ext_p2 = EXW'(r_point_end);
    assign ext_p3 = EXW'(r_point_after);

    always_comb begin
        for (int ax = 0; ax < 3; ax++) begin
            c_p0[ax] = signed'(ext_p0[ax*W +: W]);
            c_p1[ax] = signed'(ext_p1[ax*W +: W]);
            c_p2[ax] = signed'(ext_p2[ax*W +: W]);
            c_p3[ax] = signed'(ext_p3[ax*W +: W]);
        end
    end

    // Stage C1: point differences and Hermite sums
    logic signed [W+1:0]  r_c1_da [3];   // p3 - p0 - p1 + p2
    logic signed [W+2:0]  r_c1_db [3];   // 2p0 + p1 - 2p2 - p3
    logic signed [W:0]    r_c1_dc [3];   // p2 - p0
    logic signed [W:0]    r_c1_de [3];   // p1 - p2
    logic signed [W+2:0]  r_c1_ha [3];   // 2p1 - 2p2 + T1 + T2
    logic signed [W+3:0]  r_c1_hb [3];   // 3p2 - 3p1 - 2T1 - T2
    logic signed [W-1:0]  r_c1_p0 [3];
    logic signed [W-1:0]  r_c1_p1 [3];
    logic signed [SW-1:0] r_c1_s;
    logic                 r_c1_mode;

    always_ff @(posedge i_clk) begin
        r_c1_s    <= signed'({1'b0, r_tension});
        r_c1_mode <= r_curve_mode;
        for (int ax = 0; ax < 3; ax++) begin
            r_c1_da[ax] <= (W+2)'(c_p3[ax]) - (W+2)'(c_p0[ax])
                         - (W+2)'(c_p1[ax]) + (W+2)'(c_p2[ax]);
            r_c1_db[ax] <= ((W+3)'(c_p0[ax]) <<< 1) + (W+3)'(c_p1[ax])
                         - ((W+3)'(c_p2[ax]) <<< 1) - (W+3)'(c_p3[ax]);
            r_c1_dc[ax] <= (W+1)'(c_p2[ax]) - (W+1)'(c_p0[ax]);
            r_c1_de[ax] <= (W+1)'(c_p1[ax]) - (W+1)'(c_p2[ax]);
            r_c1_ha[ax] <= ((W+3)'(c_p1[ax]) <<< 1) - ((W+3)'(c_p2[ax]) <<< 1)
                         + (W+3)'(c_p0[ax]) + (W+3)'(c_p3[ax]);
            r_c1_hb[ax] <= ((W+4)'(c_p2[ax]) <<< 1) + (W+4)'(c_p2[ax])
                         - ((W+4)'(c_p1[ax]) <<< 1) - (W+4)'(c_p1[ax])
                         - ((W+4)'(c_p0[ax]) <<< 1) - (W+4)'(c_p3[ax]);
            r_c1_p0[ax] <= c_p0[ax];
            r_c1_p1[ax] <= c_p1[ax];
        end
    end

    // Stage C2: tension products
    logic signed [SMW-1:0] r_c2_ma [3];
    logic signed [SMW-1:0] r_c2_mb [3];
    logic signed [SMW-1:0] r_c2_mc [3];
    logic signed [W:0]     r_c2_de [3];
    logic signed [W+2:0]   r_c2_ha [3];
    logic signed [W+3:0]   r_c2_hb [3];
    logic signed [W-1:0]   r_c2_p0 [3];
    logic signed [W-1:0]   r_c2_p1 [3];
    logic                  r_c2_mode;

    always_ff @(posedge i_clk) begin
        r_c2_mode <= r_c1_mode;
        for (int ax = 0; ax < 3; ax++) begin
            r_c2_ma[ax] <= SMW'(r_c1_s) * SMW'(r_c1_da[ax]);
            r_c2_mb[ax] <= SMW'(r_c1_s) * SMW'(r_c1_db[ax]);
            r_c2_mc[ax] <= SMW'(r_c1_s) * SMW'(r_c1_dc[ax]);
            r_c2_de[ax] <= r_c1_de[ax];
            r_c2_ha[ax] <= r_c1_ha[ax];
            r_c2_hb[ax] <= r_c1_hb[ax];
            r_c2_p0[ax] <= r_c1_p0[ax];
            r_c2_p1[ax] <= r_c1_p1[ax];
        end
    end

    // Stage C3: add the constant-weight terms (2.0 and 3.0 in Q1.15), round to guard scale
    logic signed [SMW-1:0] n_sum_a [3];
    logic signed [SMW-1:0] n_sum_b [3];
    logic signed [SMW-1:0] n_sum_c [3];
    logic signed [CFW-1:0] n_cf_a  [3];
    logic signed [CFW-1:0] n_cf_b  [3];
    logic signed [CFW-1:0] n_cf_c  [3];

    always_comb begin
        for (int ax = 0; ax < 3; ax++) begin
            n_sum_a[ax] = r_c2_ma[ax] + (SMW'(r_c2_de[ax]) <<< (T_FRAC + 1))
                        + SMW'(CF_HALF);
            n_sum_b[ax] = r_c2_mb[ax] - (SMW'(r_c2_de[ax]) <<< (T_FRAC + 1))
                        - (SMW'(r_c2_de[ax]) <<< T_FRAC) + SMW'(CF_HALF);
            n_sum_c[ax] = r_c2_mc[ax] + SMW'(CF_HALF);
            if (r_c2_mode == MODE_HERMITE) begin
                n_cf_a[ax] = CFW'(r_c2_ha[ax]) <<< GUARD_BITS;
                n_cf_b[ax] = CFW'(r_c2_hb[ax]) <<< GUARD_BITS;
                n_cf_c[ax] = CFW'(r_c2_p0[ax]) <<< GUARD_BITS;
            end else begin
                n_cf_a[ax] = CFW'(n_sum_a[ax] >>> CF_SHIFT);
                n_cf_b[ax] = CFW'(n_sum_b[ax] >>> CF_SHIFT);
                n_cf_c[ax] = CFW'(n_sum_c[ax] >>> CF_SHIFT);
            end
        end
    end

    logic signed [CFW-1:0] r_cf_a [3];
    logic signed [CFW-1:0] r_cf_b [3];
    logic signed [CFW-1:0] r_cf_c [3];
    logic signed [CFW-1:0] r_cf_d [3];

    always_ff @(posedge i_clk) begin
        for (int ax = 0; ax < 3; ax++) begin
            r_cf_a[ax] <= n_cf_a[ax];
            r_cf_b[ax] <= n_cf_b[ax];
            r_cf_c[ax] <= n_cf_c[ax];
            r_cf_d[ax] <= CFW'(r_c2_p1[ax]) <<< GUARD_BITS;
        end
    end

    // ------------------------------------------------------------------
    // Horner pipeline control: each stage moves when it is empty or its
    // successor moves, so bubbles squeeze out behind a stalled output.
    // ------------------------------------------------------------------
    logic [HORNER_STAGES-1:0] r_vld;
    logic [HORNER_STAGES-1:0] adv;
    logic                     in_fire;

    always_comb begin
        adv[HORNER_STAGES-1] = !r_vld[HORNER_STAGES-1] || o_out.ready;
        for (int k = HORNER_STAGES - 2; k >= 0; k--) begin
            adv[k] = !r_vld[k] || adv[k+1];
        end
    end

    assign i_in.ready = adv[0] && (r_busy == '0);
    assign in_fire    = i_in.valid & i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (adv[0]) begin
                r_vld[0] <= in_fire;
            end
            for (int k = 1; k < HORNER_STAGES; k++) begin
                if (adv[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Horner datapath, three axis lanes side by side
    // ------------------------------------------------------------------
    logic signed [TW-1:0]  in_t;
    t_tval                 r_t [4];   // t alongside stages 0..3

    logic signed [P1W-1:0] r_s0_prod [3];
    logic signed [H1W-1:0] r_s1_h    [3];
    logic signed [P2W-1:0] r_s2_prod [3];
    logic signed [H2W-1:0] r_s3_h    [3];
    logic signed [P3W-1:0] r_s4_prod [3];
    logic signed [H3W-1:0] r_s5_h    [3];
    logic signed [W-1:0]   r_pos     [3];

    logic signed [P1W:0]   n_rnd1 [3];
    logic signed [P2W:0]   n_rnd2 [3];
    logic signed [P3W:0]   n_rnd3 [3];
    logic signed [H3W:0]   n_rnd4 [3];
    logic signed [H3W:0]   n_q    [3];
    logic signed [W-1:0]   n_pos  [3];

    assign in_t = signed'({1'b0, i_in.t_param});

    always_comb begin
        for (int ax = 0; ax < 3; ax++) begin
            // round half up by T_FRAC bits before each add
            n_rnd1[ax] = (P1W+1)'(r_s0_prod[ax]) + (P1W+1)'(T_HALF);
            n_rnd2[ax] = (P2W+1)'(r_s2_prod[ax]) + (P2W+1)'(T_HALF);
            n_rnd3[ax] = (P3W+1)'(r_s4_prod[ax]) + (P3W+1)'(T_HALF);
            // drop guard bits, then clamp to the coordinate range
            n_rnd4[ax] = (H3W+1)'(r_s5_h[ax]) + (H3W+1)'(G_HALF);
            n_q[ax]    = n_rnd4[ax] >>> GUARD_BITS;
            if (n_q[ax] > SAT_MAX) begin
                n_pos[ax] = W'(SAT_MAX);
            end else if (n_q[ax] < SAT_MIN) begin
                n_pos[ax] = W'(SAT_MIN);
            end else begin
                n_pos[ax] = W'(n_q[ax]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv[0]) begin
            r_t[0] <= i_in.t_param;
        end
        for (int k = 1; k < 4; k++) begin
            if (adv[k]) begin
                r_t[k] <= r_t[k-1];
            end
        end
        for (int ax = 0; ax < 3; ax++) begin
            if (adv[0]) begin
                r_s0_prod[ax] <= P1W'(r_cf_a[ax]) * P1W'(in_t);
            end
            if (adv[1]) begin
                r_s1_h[ax] <= H1W'(n_rnd1[ax] >>> T_FRAC) + H1W'(r_cf_b[ax]);
            end
            if (adv[2]) begin
                r_s2_prod[ax] <= P2W'(r_s1_h[ax]) * P2W'(signed'({1'b0, r_t[1]}));
            end
            if (adv[3]) begin
                r_s3_h[ax] <= H2W'(n_rnd2[ax] >>> T_FRAC) + H2W'(r_cf_c[ax]);
            end
            if (adv[4]) begin
                r_s4_prod[ax] <= P3W'(r_s3_h[ax]) * P3W'(signed'({1'b0, r_t[3]}));
            end
            if (adv[5]) begin
                r_s5_h[ax] <= H3W'(n_rnd3[ax] >>> T_FRAC) + H3W'(r_cf_d[ax]);
            end
            if (adv[6]) begin
                r_pos[ax] <= n_pos[ax];
            end
        end
    end

    assign o_out.valid = r_vld[HORNER_STAGES-1];
    assign o_out.pos_x = r_pos[0];
    assign o_out.pos_y = r_pos[1];
    assign o_out.pos_z = r_pos[2];

endmodule
